>>> sv/sparse_index_match_mac_cell_defines.svh
// Assertion macros used by the checker file of the sparse index match cell.
`ifndef SPARSE_INDEX_MATCH_MAC_CELL_DEFINES_SVH
`define SPARSE_INDEX_MATCH_MAC_CELL_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SIMAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIMAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/simac_pkg.sv
// Types, codes and default sizes of the sparse index match cell.
`timescale 1ns / 1ps
`default_nettype none

package simac_pkg;

   localparam int CMD_W       = 2;
   localparam int PORT_W      = 2;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;
   localparam int RSP_SLOTS   = 4;
   localparam int SLOT_W      = 2;

   localparam int QUEUE_DEPTH_DEFAULT = 8;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int INDEX_WIDTH_DEFAULT = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK = 2'd0,
      CMD_A    = 2'd1,
      CMD_B    = 2'd2,
      CMD_PSUM = 2'd3
   } cmd_type;

   typedef enum logic [PORT_W-1:0] {
      PORT_BOTTOM = 2'd0,
      PORT_RIGHT  = 2'd1,
      PORT_PSUM   = 2'd2,
      PORT_STATUS = 2'd3
   } port_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOTTOM_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_PRESENT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARALLEL_MODE  = 2'd2;

   // Only the status slot is left in the result buffer.
   localparam logic [RSP_SLOTS-1:0] MASK_STATUS_ONLY = 4'b1000;

   typedef struct packed {
      port_type                   port;
      logic signed [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]         row_index;
      logic [INDEX_W-1:0]         col_index;
      logic                       idle;
      logic                       overflow;
      logic                       last;
   } rsp_item_type;

   // The results of one tick, one slot per output port, with a mask of those present.
   typedef struct packed {
      logic [RSP_SLOTS-1:0]          mask;
      rsp_item_type [RSP_SLOTS-1:0]  item;
   } bundle_type;

endpackage

`default_nettype wire

>>> sv/simac_if.sv
// Request and response channel interfaces of the sparse index match cell.
`timescale 1ns / 1ps
`default_nettype none

interface simac_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [simac_pkg::CMD_W-1:0]           cmd;
   logic signed [simac_pkg::VALUE_W-1:0]  value;
   logic [simac_pkg::INDEX_W-1:0]         row_index;
   logic [simac_pkg::INDEX_W-1:0]         col_index;
   logic                                  bottom_busy;
   logic                                  right_busy;

   modport source (output valid, cmd, value, row_index, col_index, bottom_busy, right_busy,
                   input ready);
   modport sink   (input valid, cmd, value, row_index, col_index, bottom_busy, right_busy,
                   output ready);
endinterface

interface simac_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [simac_pkg::PORT_W-1:0]          port;
   logic signed [simac_pkg::VALUE_W-1:0]  out_value;
   logic [simac_pkg::INDEX_W-1:0]         out_row_index;
   logic [simac_pkg::INDEX_W-1:0]         out_col_index;
   logic                                  idle;
   logic                                  overflow;
   logic                                  last;

   modport source (output valid, port, out_value, out_row_index, out_col_index, idle,
                   overflow, last, input ready);
   modport sink   (input valid, port, out_value, out_row_index, out_col_index, idle,
                   overflow, last, output ready);
endinterface

`default_nettype wire

>>> sv/simac_queue.sv
// Element queue with a registered head, used for the A, B and partial-sum operands.
`timescale 1ns / 1ps
`default_nettype none

module simac_queue #(
   parameter int DEPTH = simac_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               push_data,
   input  wire logic                           pop,
   output logic [WIDTH-1:0]                    head,
   output logic [$clog2(DEPTH+1)-1:0]          count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] head_ff;
   logic             push_ok;

   // A push on a full queue is dropped; the caller flags the overflow.
   assign push_ok = push && (count_ff != CNT_W'(DEPTH));

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (push_ok && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // The new head comes straight from the write data when it lands in the head slot.
   always_ff @(posedge clock) begin
      if (push_ok && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_data;
      end else if (pop) begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head  = head_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

>>> sv/simac_rsp_buffer.sv
// Result register of the cell: holds the results of one tick and sends them one by one.
`timescale 1ns / 1ps
`default_nettype none

module simac_rsp_buffer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire simac_pkg::bundle_type  bundle,
   output logic                        free,
   simac_rsp_if.source                 rsp_chan
);

   logic [simac_pkg::RSP_SLOTS-1:0]                      mask_ff, mask_in;
   simac_pkg::rsp_item_type [simac_pkg::RSP_SLOTS-1:0]   item_ff;
   logic [simac_pkg::SLOT_W-1:0]                         sel;
   simac_pkg::rsp_item_type                              cur;
   logic                                                 take;

   // The lowest slot still marked is the next result to go out.
   always_comb begin
      sel = '0;
      for (int i = simac_pkg::RSP_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = simac_pkg::SLOT_W'(i);
         end
      end
   end

   assign cur  = item_ff[sel];
   assign take = rsp_chan.valid && rsp_chan.ready;
   assign free = (mask_ff == '0) ||
                 ((mask_ff == simac_pkg::MASK_STATUS_ONLY) && rsp_chan.ready);

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = bundle.mask;
      end else if (take) begin
         mask_in = mask_ff & (mask_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= bundle.item;
      end
   end

   assign rsp_chan.valid         = |mask_ff;
   assign rsp_chan.port          = cur.port;
   assign rsp_chan.out_value     = cur.value;
   assign rsp_chan.out_row_index = cur.row_index;
   assign rsp_chan.out_col_index = cur.col_index;
   assign rsp_chan.idle          = cur.idle;
   assign rsp_chan.overflow      = cur.overflow;
   assign rsp_chan.last          = cur.last;

endmodule

`default_nettype wire

>>> sv/sparse_index_match_mac_cell.sv
// Top level of the sparse index match multiply-accumulate cell.
//
//   channel   direction  handshake            carries
//   req_chan  in         valid / ready        cmd, value, row_index, col_index, busy flags
//   rsp_chan  out        valid / ready        port, out_value, indices, idle, overflow, last
//   csr_*     in         csr_we, no wait      csr_index, csr_wdata
//
// An item is taken into the input register and handled there against the three operand
// queues; a tick waits there while the result register is busy. Arrivals can follow back
// to back. A tick loads its one to four results into the result register, which sends one
// result per cycle while rsp_ready is high, so a tick holds the next one until its last
// result is being taken. Reset empties the queues, clears the overflow flag and sets the
// neighbour flags. While rsp_ready is low, results hold and arrivals keep flowing until a tick waits.
`timescale 1ns / 1ps
`default_nettype none

module sparse_index_match_mac_cell #(
   parameter int QUEUE_DEPTH = simac_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = simac_pkg::VALUE_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = simac_pkg::INDEX_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   simac_req_if.sink                                  req_chan,
   simac_rsp_if.source                                rsp_chan,
   input  wire logic                                  csr_we,
   input  wire logic [simac_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [simac_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ELEM_W = VALUE_WIDTH + 2 * INDEX_WIDTH;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   logic bottom_present_ff, bottom_present_in;
   logic right_present_ff, right_present_in;
   logic parallel_mode_ff, parallel_mode_in;

   // Input register.
   logic                          in_valid_ff, in_valid_in;
   logic [simac_pkg::CMD_W-1:0]   cmd_ff;
   logic [VALUE_WIDTH-1:0]        value_ff;
   logic [INDEX_WIDTH-1:0]        row_ff;
   logic [INDEX_WIDTH-1:0]        col_ff;
   logic                          bottom_busy_ff;
   logic                          right_busy_ff;

   logic overflow_ff, overflow_in;

   logic req_take, proc_go, is_tick, buf_free;

   logic [ELEM_W-1:0] arrival_elem, product_elem;
   logic [ELEM_W-1:0] a_head, b_head, psum_head, psum_front, psum_push_data;
   logic [CNT_W-1:0]  a_count, b_count, psum_count;
   logic a_push, b_push, psum_push, a_pop, b_pop, psum_pop;
   logic a_full, b_full, psum_full, a_nonempty, b_nonempty, psum_nonempty;

   logic [VALUE_WIDTH-1:0]    a_val, b_val, p_val, psum_val;
   logic [INDEX_WIDTH-1:0]    a_row, a_col, b_row, b_col, psum_row, psum_col;
   logic [2*VALUE_WIDTH-1:0]  product_full;

   logic send_bottom, send_right, product_push, overflow_set, psum_has;

   simac_pkg::bundle_type bundle;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      bottom_present_in = bottom_present_ff;
      right_present_in  = right_present_ff;
      parallel_mode_in  = parallel_mode_ff;
      if (csr_we) begin
         case (csr_index)
            simac_pkg::CSR_BOTTOM_PRESENT: bottom_present_in = csr_wdata[0];
            simac_pkg::CSR_RIGHT_PRESENT:  right_present_in  = csr_wdata[0];
            simac_pkg::CSR_PARALLEL_MODE:  parallel_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_present_ff <= 1'b1;
         right_present_ff  <= 1'b1;
         parallel_mode_ff  <= 1'b0;
      end else begin
         bottom_present_ff <= bottom_present_in;
         right_present_ff  <= right_present_in;
         parallel_mode_ff  <= parallel_mode_in;
      end
   end

   // ---------------------------------------------------------------- input register
   assign proc_go  = in_valid_ff && ((cmd_ff != simac_pkg::CMD_TICK) || buf_free);
   assign is_tick  = proc_go && (cmd_ff == simac_pkg::CMD_TICK);
   assign req_chan.ready = !in_valid_ff || proc_go;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff         <= req_chan.cmd;
         value_ff       <= req_chan.value[VALUE_WIDTH-1:0];
         row_ff         <= req_chan.row_index[INDEX_WIDTH-1:0];
         col_ff         <= req_chan.col_index[INDEX_WIDTH-1:0];
         bottom_busy_ff <= req_chan.bottom_busy;
         right_busy_ff  <= req_chan.right_busy;
      end
   end

   // ---------------------------------------------------------------- operand queues
   assign arrival_elem = {value_ff, row_ff, col_ff};

   assign a_push = proc_go && (cmd_ff == simac_pkg::CMD_A);
   assign b_push = proc_go && (cmd_ff == simac_pkg::CMD_B);

   simac_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(ELEM_W)) u_a_queue (
      .clock(clock), .reset(reset), .push(a_push), .push_data(arrival_elem),
      .pop(a_pop), .head(a_head), .count(a_count)
   );

   simac_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(ELEM_W)) u_b_queue (
      .clock(clock), .reset(reset), .push(b_push), .push_data(arrival_elem),
      .pop(b_pop), .head(b_head), .count(b_count)
   );

   simac_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(ELEM_W)) u_psum_queue (
      .clock(clock), .reset(reset), .push(psum_push), .push_data(psum_push_data),
      .pop(psum_pop), .head(psum_head), .count(psum_count)
   );

   assign a_full        = (a_count == CNT_W'(QUEUE_DEPTH));
   assign b_full        = (b_count == CNT_W'(QUEUE_DEPTH));
   assign psum_full     = (psum_count == CNT_W'(QUEUE_DEPTH));
   assign a_nonempty    = (a_count != '0);
   assign b_nonempty    = (b_count != '0);
   assign psum_nonempty = (psum_count != '0);

   assign {a_val, a_row, a_col} = a_head;
   assign {b_val, b_row, b_col} = b_head;

   // ---------------------------------------------------------------- tick decision
   assign product_full = a_val * b_val;
   assign p_val        = product_full[VALUE_WIDTH-1:0];
   assign product_elem = {p_val, a_row, b_col};

   always_comb begin
      send_bottom  = 1'b0;
      send_right   = 1'b0;
      a_pop        = 1'b0;
      b_pop        = 1'b0;
      product_push = 1'b0;
      if (is_tick) begin
         if (a_nonempty && b_nonempty) begin
            if (a_col == b_row) begin
               product_push = 1'b1;
               send_bottom  = 1'b1;
               send_right   = 1'b1;
               a_pop        = 1'b1;
               b_pop        = 1'b1;
            end else if (a_col < b_row) begin
               send_bottom = 1'b1;
               a_pop       = 1'b1;
               send_right  = parallel_mode_ff;
            end else begin
               send_right  = 1'b1;
               b_pop       = 1'b1;
               send_bottom = parallel_mode_ff;
            end
         end else if (b_nonempty) begin
            send_right = 1'b1;
            b_pop      = 1'b1;
         end else if (a_nonempty) begin
            send_bottom = 1'b1;
            a_pop       = 1'b1;
         end
      end
   end

   assign psum_push      = product_push || (proc_go && (cmd_ff == simac_pkg::CMD_PSUM));
   assign psum_push_data = is_tick ? product_elem : arrival_elem;

   // A product pushed onto an empty queue is already the partial sum that leaves this tick when there is a cell below.
   assign psum_has   = psum_nonempty || product_push;
   assign psum_front = psum_nonempty ? psum_head : product_elem;
   assign psum_pop   = is_tick && psum_has && bottom_present_ff;
   assign {psum_val, psum_row, psum_col} = psum_front;

   assign overflow_set = (a_push && a_full) || (b_push && b_full) || (psum_push && psum_full);
   assign overflow_in  = overflow_ff || overflow_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff <= 1'b0;
      end else begin
         overflow_ff <= overflow_in;
      end
   end

   // ---------------------------------------------------------------- results of a tick
   always_comb begin
      bundle.mask[simac_pkg::PORT_BOTTOM] = send_bottom && bottom_present_ff && !bottom_busy_ff;
      bundle.mask[simac_pkg::PORT_RIGHT]  = send_right && right_present_ff && !right_busy_ff;
      bundle.mask[simac_pkg::PORT_PSUM]   = psum_pop;
      bundle.mask[simac_pkg::PORT_STATUS] = 1'b1;

      bundle.item[simac_pkg::PORT_BOTTOM].port      = simac_pkg::PORT_BOTTOM;
      bundle.item[simac_pkg::PORT_BOTTOM].value     = simac_pkg::VALUE_W'(signed'(a_val));
      bundle.item[simac_pkg::PORT_BOTTOM].row_index = simac_pkg::INDEX_W'(a_row);
      bundle.item[simac_pkg::PORT_BOTTOM].col_index = simac_pkg::INDEX_W'(a_col);
      bundle.item[simac_pkg::PORT_BOTTOM].idle      = 1'b0;
      bundle.item[simac_pkg::PORT_BOTTOM].overflow  = 1'b0;
      bundle.item[simac_pkg::PORT_BOTTOM].last      = 1'b0;

      bundle.item[simac_pkg::PORT_RIGHT].port       = simac_pkg::PORT_RIGHT;
      bundle.item[simac_pkg::PORT_RIGHT].value      = simac_pkg::VALUE_W'(signed'(b_val));
      bundle.item[simac_pkg::PORT_RIGHT].row_index  = simac_pkg::INDEX_W'(b_row);
      bundle.item[simac_pkg::PORT_RIGHT].col_index  = simac_pkg::INDEX_W'(b_col);
      bundle.item[simac_pkg::PORT_RIGHT].idle       = 1'b0;
      bundle.item[simac_pkg::PORT_RIGHT].overflow   = 1'b0;
      bundle.item[simac_pkg::PORT_RIGHT].last       = 1'b0;

      bundle.item[simac_pkg::PORT_PSUM].port        = simac_pkg::PORT_PSUM;
      bundle.item[simac_pkg::PORT_PSUM].value       = simac_pkg::VALUE_W'(signed'(psum_val));
      bundle.item[simac_pkg::PORT_PSUM].row_index   = simac_pkg::INDEX_W'(psum_row);
      bundle.item[simac_pkg::PORT_PSUM].col_index   = simac_pkg::INDEX_W'(psum_col);
      bundle.item[simac_pkg::PORT_PSUM].idle        = 1'b0;
      bundle.item[simac_pkg::PORT_PSUM].overflow    = 1'b0;
      bundle.item[simac_pkg::PORT_PSUM].last        = 1'b0;

      bundle.item[simac_pkg::PORT_STATUS].port      = simac_pkg::PORT_STATUS;
      bundle.item[simac_pkg::PORT_STATUS].value     = '0;
      bundle.item[simac_pkg::PORT_STATUS].row_index = '0;
      bundle.item[simac_pkg::PORT_STATUS].col_index = '0;
      bundle.item[simac_pkg::PORT_STATUS].idle      = !a_nonempty && !b_nonempty &&
                                                      !psum_nonempty;
      bundle.item[simac_pkg::PORT_STATUS].overflow  = overflow_in;
      bundle.item[simac_pkg::PORT_STATUS].last      = 1'b1;
   end

   simac_rsp_buffer u_rsp_buffer (
      .clock    (clock),
      .reset    (reset),
      .load     (is_tick),
      .bundle   (bundle),
      .free     (buf_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/simac_checker.sv
// Port checker of the sparse index match cell and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_index_match_mac_cell_defines.svh"

module simac_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [simac_pkg::PORT_W-1:0]  rsp_port,
   input wire logic                          rsp_idle,
   input wire logic                          rsp_overflow,
   input wire logic                          rsp_last
);

   logic seen_overflow_ff, seen_overflow_in;
   logic is_status;

   assign is_status = (rsp_port == simac_pkg::PORT_STATUS);

   // Remembers that a status item has reported an overflow since reset.
   assign seen_overflow_in = seen_overflow_ff ||
                             (rsp_valid && rsp_ready && rsp_last && rsp_overflow);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_overflow_ff <= 1'b0;
      end else begin
         seen_overflow_ff <= seen_overflow_in;
      end
   end

   `SIMAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_port) && $stable(rsp_last), "stalled result changed")

   `SIMAC_ASSERT_NOW(a_last_is_status, clock, reset, rsp_valid,
      rsp_last == is_status, "last flag does not match the status port")

   `SIMAC_ASSERT_NOW(a_flags_only_status, clock, reset, rsp_valid && !is_status,
      !rsp_idle && !rsp_overflow, "status flags set on an operand or partial sum item")

   `SIMAC_ASSERT_NOW(a_overflow_sticky, clock, reset, rsp_valid && is_status && seen_overflow_ff,
      rsp_overflow, "overflow flag cleared without reset")

endmodule

bind sparse_index_match_mac_cell simac_checker u_simac_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_port     (rsp_chan.port),
   .rsp_idle     (rsp_chan.idle),
   .rsp_overflow (rsp_chan.overflow),
   .rsp_last     (rsp_chan.last)
);

`default_nettype wire

>>> tb/sparse_index_match_mac_cell_test.sv
// Self-checking testbench of the sparse index match cell: random and directed items, scoreboard.
`timescale 1ns / 1ps

module sparse_index_match_mac_cell_test;
   import simac_pkg::*;

   localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT;
   localparam int RESET_CYCLES  = 2;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 150;
   localparam int QUIET_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 10;

   // Index beyond the register file; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        row;
      logic [INDEX_W-1:0]        col;
   } cell_elem;

   // Mirrors the three queues of the cell and holds the results still due from it.
   class mac_cell_tracker;
      cell_elem     a_queue[$];
      cell_elem     b_queue[$];
      cell_elem     psum_queue[$];
      bit           overflow_seen;
      bit           bottom_present = 1'b1;
      bit           right_present  = 1'b1;
      bit           parallel_mode  = 1'b0;
      rsp_item_type due_results[$];
      int unsigned  failures;

      function void set_config(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_BOTTOM_PRESENT: bottom_present = data[0];
            CSR_RIGHT_PRESENT:  right_present  = data[0];
            CSR_PARALLEL_MODE:  parallel_mode  = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction

      function void add_result(port_type port, cell_elem e);
         rsp_item_type r;
         r = '0;
         r.port      = port;
         r.value     = e.value;
         r.row_index = e.row;
         r.col_index = e.col;
         due_results.push_back(r);
      endfunction

      function void note_item(cmd_type cmd, cell_elem e, bit bottom_busy, bit right_busy);
         cell_elem     a, b, p;
         bit           to_bottom, to_right, pop_a, pop_b, was_idle;
         rsp_item_type status;
         if (cmd != CMD_TICK) begin
            case (cmd)
               CMD_A: begin
                  if (a_queue.size() < QUEUE_DEPTH) a_queue.push_back(e);
                  else overflow_seen = 1'b1;
               end
               CMD_B: begin
                  if (b_queue.size() < QUEUE_DEPTH) b_queue.push_back(e);
                  else overflow_seen = 1'b1;
               end
               default: begin
                  if (psum_queue.size() < QUEUE_DEPTH) psum_queue.push_back(e);
                  else overflow_seen = 1'b1;
               end
            endcase
            return;
         end
         was_idle  = a_queue.size() == 0 && b_queue.size() == 0 && psum_queue.size() == 0;
         to_bottom = 1'b0;
         to_right  = 1'b0;
         pop_a     = 1'b0;
         pop_b     = 1'b0;
         if (a_queue.size() != 0 && b_queue.size() != 0) begin
            a = a_queue[0];
            b = b_queue[0];
            if (a.col == b.row) begin
               // The product keeps only the low bits of the operands' width.
               p.value = a.value * b.value;
               p.row   = a.row;
               p.col   = b.col;
               if (psum_queue.size() < QUEUE_DEPTH) psum_queue.push_back(p);
               else overflow_seen = 1'b1;
               to_bottom = 1'b1;
               to_right  = 1'b1;
               pop_a     = 1'b1;
               pop_b     = 1'b1;
            end else if (a.col < b.row) begin
               to_bottom = 1'b1;
               pop_a     = 1'b1;
               to_right  = parallel_mode;
            end else begin
               to_right  = 1'b1;
               pop_b     = 1'b1;
               to_bottom = parallel_mode;
            end
         end else if (b_queue.size() != 0) begin
            to_right = 1'b1;
            pop_b    = 1'b1;
         end else if (a_queue.size() != 0) begin
            to_bottom = 1'b1;
            pop_a     = 1'b1;
         end
         if (to_bottom && bottom_present && !bottom_busy) add_result(PORT_BOTTOM, a_queue[0]);
         if (to_right && right_present && !right_busy) add_result(PORT_RIGHT, b_queue[0]);
         if (pop_a) void'(a_queue.pop_front());
         if (pop_b) void'(b_queue.pop_front());
         // A partial sum waits in its queue while there is no cell below.
         if (psum_queue.size() != 0 && bottom_present) add_result(PORT_PSUM, psum_queue.pop_front());
         status          = '0;
         status.port     = PORT_STATUS;
         status.idle     = was_idle;
         status.overflow = overflow_seen;
         status.last     = 1'b1;
         due_results.push_back(status);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (due_results.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result: port %0d value %h row %h col %h last %b",
                        got.port, got.value, got.row_index, got.col_index, got.last);
            return;
         end
         want = due_results.pop_front();
         if (got.port !== want.port || got.value !== want.value ||
             got.row_index !== want.row_index || got.col_index !== want.col_index ||
             got.idle !== want.idle || got.overflow !== want.overflow ||
             got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("result mismatch: expected port %0d value %h row %h col %h idle %b ovf %b last %b",
                        want.port, want.value, want.row_index, want.col_index,
                        want.idle, want.overflow, want.last);
               $display("                 actual   port %0d value %h row %h col %h idle %b ovf %b last %b",
                        got.port, got.value, got.row_index, got.col_index,
                        got.idle, got.overflow, got.last);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   simac_req_if req_chan();
   simac_rsp_if rsp_chan();

   mac_cell_tracker board;
   bit              req_gaps_on = 1'b1;
   bit              rsp_gaps_on = 1'b1;
   bit              long_hold_go = 1'b0;
   int unsigned     quiet_cycles = 0;

   sparse_index_match_mac_cell uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin : monitor
      rsp_item_type got;
      cell_elem     item;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.port      = port_type'(rsp_chan.port);
            got.value     = rsp_chan.out_value;
            got.row_index = rsp_chan.out_row_index;
            got.col_index = rsp_chan.out_col_index;
            got.idle      = rsp_chan.idle;
            got.overflow  = rsp_chan.overflow;
            got.last      = rsp_chan.last;
            board.check_result(got);
         end
         if (req_chan.valid && req_chan.ready) begin
            item.value = req_chan.value;
            item.row   = req_chan.row_index;
            item.col   = req_chan.col_index;
            board.note_item(cmd_type'(req_chan.cmd), item, req_chan.bottom_busy,
                            req_chan.right_busy);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // The receiver counts its own hold-offs, short random ones and the single long one.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left    = LONG_HOLD;
         end else if (hold_left == 0 && rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 4);
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return r;
      endcase
   endfunction

   // Mostly small indices so that heads match often; now and then the full range.
   function automatic logic [INDEX_W-1:0] rand_index();
      logic [31:0] r;
      if ($urandom_range(0, 3) == 0) r = $urandom();
      else r = $urandom_range(0, 3);
      return r[INDEX_W-1:0];
   endfunction

   function automatic bit rand_busy();
      return $urandom_range(0, 3) == 0;
   endfunction

   task automatic send_item(cmd_type cmd, logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] row,
                            logic [INDEX_W-1:0] col, bit bottom_busy, bit right_busy);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.value       <= value;
      req_chan.row_index   <= row;
      req_chan.col_index   <= col;
      req_chan.bottom_busy <= bottom_busy;
      req_chan.right_busy  <= right_busy;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // A tick carries random value and index fields, which the cell must ignore.
   task automatic send_tick(bit bottom_busy, bit right_busy);
      send_item(CMD_TICK, rand_value(), rand_index(), rand_index(), bottom_busy, right_busy);
   endtask

   task automatic send_random(int unsigned count);
      int unsigned sent, roll, burst;
      cmd_type     cmd;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // Flood one queue with a burst of two items fewer up to two items more than its depth.
            case ($urandom_range(0, 2))
               0: cmd = CMD_A;
               1: cmd = CMD_B;
               default: cmd = CMD_PSUM;
            endcase
            burst = $urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 2);
         end else begin
            burst = 1;
            if (roll < 35) cmd = CMD_A;
            else if (roll < 64) cmd = CMD_B;
            else if (roll < 72) cmd = CMD_PSUM;
            else cmd = CMD_TICK;
         end
         repeat (burst) begin
            send_item(cmd, rand_value(), rand_index(), rand_index(), rand_busy(), rand_busy());
            sent++;
         end
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      board.set_config(index, data);
      @(posedge clock);
   endtask

   task automatic apply_config(bit bottom, bit right, bit parallel);
      write_reg(CSR_BOTTOM_PRESENT, bottom);
      write_reg(CSR_RIGHT_PRESENT, right);
      write_reg(CSR_PARALLEL_MODE, parallel);
      write_reg(CSR_UNUSED, $urandom_range(0, 1) == 1);
      csr_we <= 1'b0;
   endtask

   // Stop offering items and wait until every result has come and the cell is quiet.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      board = new();
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= CMD_TICK;
      req_chan.value       <= '0;
      req_chan.row_index   <= '0;
      req_chan.col_index   <= '0;
      req_chan.bottom_busy <= 1'b0;
      req_chan.right_busy  <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_BOTTOM_PRESENT;
      csr_wdata            <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_config(1'b1, 1'b1, 1'b0);
      // With every queue empty a tick gives only the status item, with idle set.
      send_tick(1'b0, 1'b0);
      // Busy flags on arrival items are ignored.
      send_item(CMD_A, 32'h8000_0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
      send_item(CMD_B, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_item(CMD_A, 32'hFFFF_FFFF, 16'h0001, 16'h0005, 1'b0, 1'b0);
      send_item(CMD_B, 32'h0000_0003, 16'h0003, 16'h0002, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_item(CMD_B, 32'h0000_0007, 16'h0009, 16'h0001, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_item(CMD_A, 32'h1234_5678, 16'h0000, 16'h0002, 1'b0, 1'b0);
      send_item(CMD_B, 32'h8765_4321, 16'h0004, 16'h0000, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      // A partial sum leaves even when the cell below reports busy.
      send_item(CMD_PSUM, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_item(CMD_A, 32'h0000_0000, 16'h5555, 16'hFFFF, 1'b0, 1'b0);
      send_item(CMD_B, 32'h0000_0000, 16'hFFFF, 16'hAAAA, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_random(50);
      settle();

      apply_config(1'b1, 1'b1, 1'b1);
      send_random(50);
      // The receiver holds off for a long stretch while items keep coming, so the cell fills.
      req_gaps_on  = 1'b0;
      long_hold_go = 1'b1;
      send_random(60);
      req_gaps_on  = 1'b1;
      settle();

      apply_config(1'b0, 1'b1, 1'b0);
      send_random(50);
      settle();

      apply_config(1'b1, 1'b0, 1'b1);
      send_random(50);
      settle();

      apply_config(1'b0, 1'b0, 1'b1);
      send_random(40);
      settle();

      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      apply_config(1'b1, 1'b1, 1'b0);
      send_random(60);
      settle();

      if (board.failures == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/simac_pkg.sv
sv/simac_if.sv
sv/simac_queue.sv
sv/simac_rsp_buffer.sv
sv/sparse_index_match_mac_cell.sv
sv/simac_checker.sv
tb/sparse_index_match_mac_cell_test.sv
